// ===== hdl/bfr_pkg.sv =====
// Shared types and constants for the bitmap font text renderer.
// No dependencies; all other files but bfr_ram refer to it by scoped names.
`timescale 1ns / 1ps
package bfr_pkg;

  // Field widths fixed by the interface.
  localparam int COORD_W = 10;
  localparam int CURSOR_W = 11;
  localparam int CALC_W = 12;
  localparam int FONT_AW = 8;
  localparam int FONT_DW = 64;
  // Widest atlas cell origin over the whole parameter range.
  localparam int CX_W = 10;
  localparam int CY_W = 11;
  // Font memory covers a 128 by 128 pixel atlas.
  localparam int FONT_SPAN = 128;

  localparam logic [7:0] CHAR_FIRST = 8'd32;
  localparam logic [7:0] CHAR_LF = 8'd10;
  localparam logic [7:0] CHAR_CR = 8'd13;

  localparam int OUT_DEPTH = 4;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_CHAR  = 2'd1,
    OP_LOAD  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CMD_FONT  = 2'd0,
    CMD_GLYPH = 2'd1,
    CMD_HALT  = 2'd2
  } cmd_kind_t;

  typedef enum logic [1:0] {
    REG_ORIGIN_X   = 2'd0,
    REG_ORIGIN_Y   = 2'd1,
    REG_OUT_WIDTH  = 2'd2,
    REG_OUT_HEIGHT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [FONT_AW-1:0]    addr;
    logic [FONT_DW-1:0]    bits;
    logic [CURSOR_W-1:0]   col;
    logic [CURSOR_W-1:0]   row;
    logic [CX_W-1:0]       cx;
    logic [CY_W-1:0]       cy;
  } cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0]  origin_x;
    logic [COORD_W-1:0]  origin_y;
    logic [CURSOR_W-1:0] out_width;
    logic [CURSOR_W-1:0] out_height;
  } cfg_t;

  typedef struct packed {
    logic               push;
    logic               pop;
    logic               full;
    logic               empty;
  } q_stat_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               on;
    logic               halted;
    logic               last;
  } pix_t;

endpackage

// ===== hdl/bitmap_font_text_renderer_top.sv =====
// Top level: configuration registers, front end, command queue, render engine.
// Depends on bfr_pkg, bfr_front, bfr_cmd_fifo, bfr_back.
// A glyph passes through the command queue, the glyph walk, the pixel stage and
// the result buffer. A glyph gives (CELL_WIDTH-1)*CELL_HEIGHT pixels (56 at 8x8), one
// pixel a cycle from the single font memory read port while the result buffer has room;
// the engine ends a glyph before it takes the next command. Reset clears cursor, stop
// flag and queues, sets origin 0, size 640x480; font memory is undefined until loaded.
`timescale 1ns / 1ps
module bitmap_font_text_renderer_top #(
  parameter int GLYPH_COLUMNS = 16,
  parameter int GLYPH_ROWS = 16,
  parameter int CELL_WIDTH = 8,
  parameter int CELL_HEIGHT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode,
  input  logic [7:0]  char_code,
  input  logic [7:0]  font_addr,
  input  logic [63:0] font_bits,
  output logic        empty,
  input  logic        pop,
  output logic [9:0]  pixel_x,
  output logic [9:0]  pixel_y,
  output logic        pixel_on,
  output logic        halted,
  output logic        last
);

  bfr_pkg::cfg_t    cfg;
  bfr_pkg::cmd_t    q_wcmd;
  bfr_pkg::cmd_t    q_rcmd;
  bfr_pkg::q_stat_t qs;
  bfr_pkg::pix_t    head;
  bfr_pkg::reg_idx_t reg_sel;
  logic             cfg_we;

  assign pready  = 1'b1;
  assign reg_sel = bfr_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x   <= '0;
      cfg.origin_y   <= '0;
      cfg.out_width  <= 11'd640;
      cfg.out_height <= 11'd480;
    end else if (cfg_we) begin
      unique case (reg_sel)
        bfr_pkg::REG_ORIGIN_X:   cfg.origin_x   <= pwdata[9:0];
        bfr_pkg::REG_ORIGIN_Y:   cfg.origin_y   <= pwdata[9:0];
        bfr_pkg::REG_OUT_WIDTH:  cfg.out_width  <= pwdata[10:0];
        bfr_pkg::REG_OUT_HEIGHT: cfg.out_height <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      bfr_pkg::REG_ORIGIN_X:   prdata = {22'd0, cfg.origin_x};
      bfr_pkg::REG_ORIGIN_Y:   prdata = {22'd0, cfg.origin_y};
      bfr_pkg::REG_OUT_WIDTH:  prdata = {21'd0, cfg.out_width};
      bfr_pkg::REG_OUT_HEIGHT: prdata = {21'd0, cfg.out_height};
      default:                 prdata = '0;
    endcase
  end

  bfr_front #(
    .GLYPH_COLUMNS (GLYPH_COLUMNS),
    .CELL_WIDTH    (CELL_WIDTH),
    .CELL_HEIGHT   (CELL_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .opcode    (opcode),
    .char_code (char_code),
    .font_addr (font_addr),
    .font_bits (font_bits),
    .cfg       (cfg),
    .q_full    (qs.full),
    .q_push    (qs.push),
    .q_cmd     (q_wcmd)
  );

  bfr_cmd_fifo u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (qs.push),
    .wdata (q_wcmd),
    .full  (qs.full),
    .pop   (qs.pop),
    .rdata (q_rcmd),
    .empty (qs.empty)
  );

  bfr_back #(
    .GLYPH_COLUMNS (GLYPH_COLUMNS),
    .GLYPH_ROWS    (GLYPH_ROWS),
    .CELL_WIDTH    (CELL_WIDTH),
    .CELL_HEIGHT   (CELL_HEIGHT)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_cmd   (q_rcmd),
    .q_empty (qs.empty),
    .q_pop   (qs.pop),
    .pop     (pop),
    .empty   (empty),
    .head    (head)
  );

  assign full     = qs.full;
  assign pixel_x  = head.x;
  assign pixel_y  = head.y;
  assign pixel_on = head.on;
  assign halted   = head.halted;
  assign last     = head.last;

  // A halt beat always closes its input and never lights a pixel.
  a_halt_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && halted) |-> (last && !pixel_on))
    else $error("halt beat without last or with pixel set");

  // The front end must not queue into a full command queue.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    qs.push |-> !qs.full)
    else $error("command pushed while queue full");

  // The engine must not take from an empty command queue.
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    qs.pop |-> !qs.empty)
    else $error("command popped while queue empty");

endmodule

// ===== hdl/bfr_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module bfr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/bfr_cmd_fifo.sv =====
// Two-entry command queue between the front end and the render engine.
// Depends on bfr_pkg for the command type.
`timescale 1ns / 1ps
module bfr_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bfr_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output bfr_pkg::cmd_t rdata,
  output logic          empty
);

  bfr_pkg::cmd_t slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wdata;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/bfr_front.sv =====
// Front end: takes input beats, keeps the text cursor and stop flag, and
// queues font writes, glyph jobs and halt results. Depends on bfr_pkg.
`timescale 1ns / 1ps
module bfr_front #(
  parameter int GLYPH_COLUMNS = 16,
  parameter int CELL_WIDTH = 8,
  parameter int CELL_HEIGHT = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [1:0]                   opcode,
  input  logic [7:0]                   char_code,
  input  logic [bfr_pkg::FONT_AW-1:0]  font_addr,
  input  logic [bfr_pkg::FONT_DW-1:0]  font_bits,
  input  bfr_pkg::cfg_t                cfg,
  input  logic                         q_full,
  output logic                         q_push,
  output bfr_pkg::cmd_t                q_cmd
);

  localparam int ATLAS_W = GLYPH_COLUMNS * CELL_WIDTH;

  logic [bfr_pkg::CX_W-1:0] cx_tab [128];
  logic [bfr_pkg::CY_W-1:0] cy_tab [128];

  for (genvar g = 0; g < 128; g++) begin : g_tab
    localparam int CXV = (g * CELL_WIDTH) % ATLAS_W;
    localparam int CYV = ((g * CELL_WIDTH) / ATLAS_W) * CELL_HEIGHT;
    assign cx_tab[g] = bfr_pkg::CX_W'(CXV);
    assign cy_tab[g] = bfr_pkg::CY_W'(CYV);
  end

  logic [bfr_pkg::CURSOR_W-1:0] col;
  logic [bfr_pkg::CURSOR_W-1:0] row;
  logic                         stopped;
  logic [bfr_pkg::CURSOR_W-1:0] col_next;
  logic [bfr_pkg::CURSOR_W-1:0] row_next;
  logic                         stopped_next;

  logic                         accept;
  logic                         enq;
  logic                         wrap;
  logic                         bottom;
  logic                         printable;
  logic [bfr_pkg::CURSOR_W-1:0] org_x;
  logic [bfr_pkg::CURSOR_W-1:0] row_add;
  logic [bfr_pkg::CURSOR_W-1:0] col_w;
  logic [bfr_pkg::CURSOR_W-1:0] row_w;

  assign accept    = push && !q_full;
  assign q_push    = accept && enq;
  assign org_x     = {1'b0, cfg.origin_x};
  assign printable = (char_code >= bfr_pkg::CHAR_FIRST) && !char_code[7];
  assign row_add   = row + bfr_pkg::CURSOR_W'(CELL_HEIGHT);
  assign wrap      = ({1'b0, col} + bfr_pkg::CALC_W'(CELL_WIDTH)) > {1'b0, cfg.out_width};
  assign col_w     = wrap ? org_x : col;
  assign row_w     = wrap ? row_add : row;
  assign bottom    = ({1'b0, row_w} + bfr_pkg::CALC_W'(CELL_HEIGHT)) > {1'b0, cfg.out_height};

  always_comb begin
    enq          = 1'b0;
    q_cmd        = '0;
    q_cmd.kind   = bfr_pkg::CMD_HALT;
    col_next     = col;
    row_next     = row;
    stopped_next = stopped;
    unique case (bfr_pkg::op_t'(opcode))
      bfr_pkg::OP_LOAD: begin
        enq        = 1'b1;
        q_cmd.kind = bfr_pkg::CMD_FONT;
        q_cmd.addr = font_addr;
        q_cmd.bits = font_bits;
      end
      bfr_pkg::OP_START: begin
        col_next     = org_x;
        row_next     = {1'b0, cfg.origin_y};
        stopped_next = 1'b0;
      end
      bfr_pkg::OP_CHAR: begin
        priority if (stopped) begin
          enq = 1'b1;
        end else if (printable) begin
          // Wrap first, then check the bottom edge against the wrapped row.
          col_next = col_w;
          row_next = row_w;
          enq      = 1'b1;
          if (bottom) begin
            stopped_next = 1'b1;
          end else begin
            q_cmd.kind = bfr_pkg::CMD_GLYPH;
            q_cmd.col  = col_w;
            q_cmd.row  = row_w;
            q_cmd.cx   = cx_tab[char_code[6:0]];
            q_cmd.cy   = cy_tab[char_code[6:0]];
            col_next   = col_w + bfr_pkg::CURSOR_W'(CELL_WIDTH - 1);
          end
        end else if (char_code == bfr_pkg::CHAR_LF || char_code == bfr_pkg::CHAR_CR) begin
          col_next = org_x;
          row_next = row_add;
          if (row_add > cfg.out_height) begin
            enq          = 1'b1;
            stopped_next = 1'b1;
          end
        end else begin
          enq = 1'b0;
        end
      end
      default: begin
        enq = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      stopped <= 1'b0;
    end else if (accept) begin
      col     <= col_next;
      row     <= row_next;
      stopped <= stopped_next;
    end
  end

endmodule

// ===== hdl/bfr_back.sv =====
// Render engine: pops commands, writes the font memory, walks glyph cells
// column by column and buffers pixel results. Depends on bfr_pkg, bfr_ram.
`timescale 1ns / 1ps
module bfr_back #(
  parameter int GLYPH_COLUMNS = 16,
  parameter int GLYPH_ROWS = 16,
  parameter int CELL_WIDTH = 8,
  parameter int CELL_HEIGHT = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  bfr_pkg::cfg_t cfg,
  input  bfr_pkg::cmd_t q_cmd,
  input  logic          q_empty,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output bfr_pkg::pix_t head
);

  localparam int ATLAS_W = GLYPH_COLUMNS * CELL_WIDTH;
  localparam int ATLAS_H = GLYPH_ROWS * CELL_HEIGHT;
  localparam int KW = $clog2(CELL_WIDTH);
  localparam int RW = $clog2(CELL_HEIGHT + 1);
  localparam int OAW = $clog2(bfr_pkg::OUT_DEPTH);
  localparam int OCW = $clog2(bfr_pkg::OUT_DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_GLYPH
  } state_t;

  state_t                        state;
  logic [bfr_pkg::CURSOR_W-1:0]  col;
  logic [bfr_pkg::CURSOR_W-1:0]  row;
  logic [bfr_pkg::CX_W-1:0]      cx;
  logic [bfr_pkg::CY_W-1:0]      cy;
  logic [KW-1:0]                 k;
  logic [RW-1:0]                 r;

  // Pixel stage, registered alongside the font word read.
  logic                          vb;
  logic [bfr_pkg::COORD_W-1:0]   bx;
  logic [bfr_pkg::COORD_W-1:0]   by;
  logic                          b_off;
  logic [5:0]                    b_bit;
  logic                          b_halt;
  logic                          b_last;

  // Result buffer.
  bfr_pkg::pix_t                 obuf [bfr_pkg::OUT_DEPTH];
  logic [OAW-1:0]                owp;
  logic [OAW-1:0]                orp;
  logic [OCW-1:0]                ocnt;
  logic                          owr;
  logic                          ord;
  bfr_pkg::pix_t                 oin;

  logic                          credit;
  logic                          issue_pix;
  logic                          issue_halt;
  logic                          row_end;
  logic                          col_end;
  logic                          ram_we;
  logic [bfr_pkg::FONT_DW-1:0]   rdata;
  logic [bfr_pkg::FONT_AW-1:0]   raddr;
  logic [bfr_pkg::CALC_W-1:0]    px;
  logic [bfr_pkg::CALC_W-1:0]    py;
  logic [bfr_pkg::CALC_W-1:0]    axp;
  logic [bfr_pkg::CALC_W-1:0]    ax;
  logic [bfr_pkg::CALC_W-1:0]    ay;
  logic                          clip;
  logic                          aoff;

  // Leave room for the beat already in the pixel stage.
  assign credit = ({1'b0, ocnt} + {{OCW{1'b0}}, vb}) < (OCW + 1)'(bfr_pkg::OUT_DEPTH);

  assign ram_we     = (state == S_IDLE) && !q_empty && (q_cmd.kind == bfr_pkg::CMD_FONT);
  assign issue_halt = (state == S_IDLE) && !q_empty && (q_cmd.kind == bfr_pkg::CMD_HALT)
                      && credit;
  assign issue_pix  = (state == S_GLYPH) && credit;
  assign q_pop      = (state == S_IDLE) && !q_empty &&
                      ((q_cmd.kind != bfr_pkg::CMD_HALT) || credit);

  assign row_end = (r == RW'(CELL_HEIGHT - 1));
  assign col_end = (k == KW'(CELL_WIDTH - 2));

  assign px   = {1'b0, col} + bfr_pkg::CALC_W'(k);
  assign py   = {1'b0, row} + bfr_pkg::CALC_W'(r);
  assign clip = (px >= {1'b0, cfg.out_width}) || (py >= {1'b0, cfg.out_height});

  // Atlas column runs one left of the cell; column minus one is off.
  assign axp  = bfr_pkg::CALC_W'(cx) + bfr_pkg::CALC_W'(k);
  assign ax   = axp - bfr_pkg::CALC_W'(1);
  assign ay   = bfr_pkg::CALC_W'(cy) + bfr_pkg::CALC_W'(r);
  assign aoff = (axp == '0) || (ax >= bfr_pkg::CALC_W'(ATLAS_W))
                || (ay >= bfr_pkg::CALC_W'(ATLAS_H))
                || (ax >= bfr_pkg::CALC_W'(bfr_pkg::FONT_SPAN))
                || (ay >= bfr_pkg::CALC_W'(bfr_pkg::FONT_SPAN));
  assign raddr = {ay[6:0], ax[6]};

  bfr_ram #(
    .WIDTH (bfr_pkg::FONT_DW),
    .DEPTH (1 << bfr_pkg::FONT_AW)
  ) u_font_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_cmd.addr),
    .wdata (q_cmd.bits),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vb    <= 1'b0;
    end else begin
      vb <= issue_pix || issue_halt;
      unique case (state)
        S_IDLE: begin
          if (q_pop && (q_cmd.kind == bfr_pkg::CMD_GLYPH)) begin
            state <= S_GLYPH;
          end
        end
        S_GLYPH: begin
          if (issue_pix && row_end && col_end) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end

    if (state == S_IDLE) begin
      col <= q_cmd.col;
      row <= q_cmd.row;
      cx  <= q_cmd.cx;
      cy  <= q_cmd.cy;
      k   <= '0;
      r   <= '0;
    end else if (issue_pix) begin
      if (row_end) begin
        r <= '0;
        k <= k + KW'(1);
      end else begin
        r <= r + RW'(1);
      end
    end

    b_halt <= issue_halt;
    if (issue_halt) begin
      bx     <= '0;
      by     <= '0;
      b_off  <= 1'b1;
      b_bit  <= '0;
      b_last <= 1'b1;
    end else begin
      bx     <= px[bfr_pkg::COORD_W-1:0];
      by     <= py[bfr_pkg::COORD_W-1:0];
      b_off  <= clip || aoff;
      b_bit  <= ax[5:0];
      b_last <= row_end && col_end;
    end
  end

  assign owr        = vb;
  assign ord        = pop && !empty;
  assign empty      = (ocnt == '0);
  assign head       = obuf[orp];
  assign oin.x      = bx;
  assign oin.y      = by;
  assign oin.on     = !b_off && rdata[b_bit];
  assign oin.halted = b_halt;
  assign oin.last   = b_last;

  always_ff @(posedge clk) begin
    if (owr) begin
      obuf[owp] <= oin;
    end
    if (rst) begin
      owp  <= '0;
      orp  <= '0;
      ocnt <= '0;
    end else begin
      if (owr) begin
        owp <= owp + OAW'(1);
      end
      if (ord) begin
        orp <= orp + OAW'(1);
      end
      unique case ({owr, ord})
        2'b10:   ocnt <= ocnt + OCW'(1);
        2'b01:   ocnt <= ocnt - OCW'(1);
        default: ocnt <= ocnt;
      endcase
    end
  end

endmodule

// ===== verif/tb_bitmap_font_text_renderer_top.sv =====
// Self-checking testbench for bitmap_font_text_renderer_top: queued stimulus with bursty
// push, stalling pop, and a cycle-free predictor of cursor, stop flag and font atlas.
// Depends on bfr_pkg and the RTL under hdl/.
`timescale 1ns / 1ps
module tb_bitmap_font_text_renderer_top;

  localparam int GLYPH_COLUMNS = 16;
  localparam int GLYPH_ROWS = 16;
  localparam int CELL_WIDTH = 8;
  localparam int CELL_HEIGHT = 8;
  localparam int ATLAS_W = GLYPH_COLUMNS * CELL_WIDTH;
  localparam int ATLAS_H = GLYPH_ROWS * CELL_HEIGHT;
  localparam logic [7:0] CHAR_LAST = 8'd127;
  // Font words covered by the printable glyphs; only these are ever read.
  localparam int FIRST_WORD =
    (bfr_pkg::CHAR_FIRST * CELL_WIDTH / ATLAS_W) * CELL_HEIGHT * 2;
  localparam int LAST_WORD =
    ((CHAR_LAST * CELL_WIDTH / ATLAS_W) * CELL_HEIGHT + CELL_HEIGHT) * 2 - 1;
  localparam int RANDOM_PER_PHASE = 60;
  localparam int DRAIN_CYCLES = 64;
  localparam int LIMIT_NS = 4_000_000;

  typedef struct {
    bfr_pkg::op_t op;
    logic [7:0]   code;
    logic [7:0]   addr;
    logic [63:0]  bits;
  } text_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  opcode = '0;
  logic [7:0]  char_code = '0;
  logic [7:0]  font_addr = '0;
  logic [63:0] font_bits = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [9:0]  pixel_x;
  logic [9:0]  pixel_y;
  logic        pixel_on;
  logic        halted;
  logic        last;

  bitmap_font_text_renderer_top #(
    .GLYPH_COLUMNS(GLYPH_COLUMNS),
    .GLYPH_ROWS(GLYPH_ROWS),
    .CELL_WIDTH(CELL_WIDTH),
    .CELL_HEIGHT(CELL_HEIGHT)
  ) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .push(push), .full(full), .opcode(opcode), .char_code(char_code),
    .font_addr(font_addr), .font_bits(font_bits),
    .empty(empty), .pop(pop), .pixel_x(pixel_x), .pixel_y(pixel_y),
    .pixel_on(pixel_on), .halted(halted), .last(last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Predictor state.
  int          org_x = 0;
  int          org_y = 0;
  int          pic_w = 640;
  int          pic_h = 480;
  int          text_col = 0;
  int          text_row = 0;
  bit          text_stopped = 1'b0;
  logic [63:0] atlas_words [256];

  text_item_t     text_items [$];
  bfr_pkg::pix_t  expected_pixels [$];
  int             mismatch_count = 0;

  function automatic bit atlas_pixel(int ax, int ay);
    if (ax < 0 || ay < 0 || ax >= ATLAS_W || ay >= ATLAS_H || ax >= 128 || ay >= 128)
      return 1'b0;
    return atlas_words[(ay * 2 + (ax >> 6)) & 255][ax & 63];
  endfunction

  function automatic void stop_text();
    bfr_pkg::pix_t p;
    p = '{x: '0, y: '0, on: 1'b0, halted: 1'b1, last: 1'b1};
    text_stopped = 1'b1;
    expected_pixels.push_back(p);
  endfunction

  function automatic void predict_pixels(text_item_t it);
    int            base;
    int            cx;
    int            cy;
    int            px;
    int            py;
    bfr_pkg::pix_t p;
    case (it.op)
      bfr_pkg::OP_LOAD: atlas_words[it.addr] = it.bits;
      bfr_pkg::OP_START: begin
        text_col = org_x;
        text_row = org_y;
        text_stopped = 1'b0;
      end
      bfr_pkg::OP_CHAR: begin
        if (text_stopped) begin
          stop_text();
        end else if (it.code >= bfr_pkg::CHAR_FIRST && it.code <= CHAR_LAST) begin
          base = it.code * CELL_WIDTH;
          cx = base % ATLAS_W;
          cy = (base / ATLAS_W) * CELL_HEIGHT;
          if (text_col + CELL_WIDTH > pic_w) begin
            text_col = org_x;
            text_row = (text_row + CELL_HEIGHT) & 'h7FF;
          end
          if (text_row + CELL_HEIGHT > pic_h) begin
            stop_text();
          end else begin
            for (int k = 0; k < CELL_WIDTH - 1; k++) begin
              for (int r = 0; r < CELL_HEIGHT; r++) begin
                px = text_col + k;
                py = text_row + r;
                p.x = px[9:0];
                p.y = py[9:0];
                p.on = (px < pic_w && py < pic_h) ? atlas_pixel(cx - 1 + k, cy + r) : 1'b0;
                p.halted = 1'b0;
                p.last = (k == CELL_WIDTH - 2) && (r == CELL_HEIGHT - 1);
                expected_pixels.push_back(p);
              end
            end
            text_col = (text_col + CELL_WIDTH - 1) & 'h7FF;
          end
        end else if (it.code == bfr_pkg::CHAR_LF || it.code == bfr_pkg::CHAR_CR) begin
          text_col = org_x;
          text_row = (text_row + CELL_HEIGHT) & 'h7FF;
          if (text_row > pic_h) stop_text();
        end
      end
      default: ;
    endcase
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) predict_pixels(text_items.pop_front());
      if (!(push && full)) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (text_items.size() > 0) begin
          opcode <= text_items[0].op;
          char_code <= text_items[0].code;
          font_addr <= text_items[0].addr;
          font_bits <= text_items[0].bits;
          push <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: the stall style steps through four styles, one of which never stalls.
  int rx_cycle = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      rx_cycle++;
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        case ((rx_cycle >> 8) & 3)
          1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
          2: if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(4, 12);
          3: if ($urandom_range(0, 1) == 0) stall_left = 1;
          default: stall_left = 0;
        endcase
        pop <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  function automatic void check_field(string name, logic [9:0] want, logic [9:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    bfr_pkg::pix_t want;
    if (!rst && pop && !empty) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected beat: x=%0d y=%0d on=%b halted=%b last=%b",
               pixel_x, pixel_y, pixel_on, halted, last);
        mismatch_count++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("pixel_x", want.x, pixel_x);
        check_field("pixel_y", want.y, pixel_y);
        check_field("pixel_on", 10'(want.on), 10'(pixel_on));
        check_field("halted", 10'(want.halted), 10'(halted));
        check_field("last", 10'(want.last), 10'(last));
      end
    end
  end

  task automatic write_reg(bfr_pkg::reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      bfr_pkg::REG_ORIGIN_X:   org_x = value & 1023;
      bfr_pkg::REG_ORIGIN_Y:   org_y = value & 1023;
      bfr_pkg::REG_OUT_WIDTH:  pic_w = value & 'h7FF;
      bfr_pkg::REG_OUT_HEIGHT: pic_h = value & 'h7FF;
      default: ;
    endcase
  endtask

  task automatic set_picture(int ox, int oy, int w, int h);
    write_reg(bfr_pkg::REG_ORIGIN_X, ox);
    write_reg(bfr_pkg::REG_ORIGIN_Y, oy);
    write_reg(bfr_pkg::REG_OUT_WIDTH, w);
    write_reg(bfr_pkg::REG_OUT_HEIGHT, h);
  endtask

  // Hold until every item is taken and every pixel seen, then let loads and cursor
  // moves still queued behind the last glyph retire.
  task automatic wait_idle();
    while (text_items.size() != 0 || push || expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void add_item(bfr_pkg::op_t op, logic [7:0] code);
    text_item_t it;
    it.op = op;
    it.code = code;
    it.addr = 8'($urandom_range(0, 255));
    it.bits = {$urandom, $urandom};
    text_items.push_back(it);
  endfunction

  function automatic void add_load(logic [7:0] addr, logic [63:0] bits);
    text_item_t it;
    it.op = bfr_pkg::OP_LOAD;
    it.code = 8'($urandom_range(0, 255));
    it.addr = addr;
    it.bits = bits;
    text_items.push_back(it);
  endfunction

  // Mostly well-formed text with random content, the rest noise.
  function automatic void add_random_items(int n);
    int          pick;
    logic [7:0]  code;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        add_item(bfr_pkg::OP_START, 8'($urandom_range(0, 255)));
      end else if (pick < 70) begin
        add_item(bfr_pkg::OP_CHAR, 8'($urandom_range(bfr_pkg::CHAR_FIRST, CHAR_LAST)));
      end else if (pick < 78) begin
        add_item(bfr_pkg::OP_CHAR,
                 $urandom_range(0, 1) ? bfr_pkg::CHAR_LF : bfr_pkg::CHAR_CR);
      end else if (pick < 84) begin
        if ($urandom_range(0, 1)) begin
          code = 8'($urandom_range(128, 255));
        end else begin
          do code = 8'($urandom_range(0, 31));
          while (code == bfr_pkg::CHAR_LF || code == bfr_pkg::CHAR_CR);
        end
        add_item(bfr_pkg::OP_CHAR, code);
      end else if (pick < 92) begin
        add_load(8'($urandom_range(0, 255)), {$urandom, $urandom});
      end else if (pick < 96) begin
        add_item(bfr_pkg::OP_NONE, 8'($urandom_range(0, 255)));
      end else begin
        add_item(bfr_pkg::OP_CHAR, 8'($urandom_range(0, 255)));
      end
    end
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Fill every font word a glyph can reach before any text goes in.
    for (int w = FIRST_WORD; w <= LAST_WORD; w++) add_load(8'(w), {$urandom, $urandom});
    add_load(8'd0, 64'd0);
    add_load(8'd255, '1);
    add_load(8'd64, '1);
    add_load(8'd66, 64'd0);
    add_item(bfr_pkg::OP_START, 8'd0);
    add_item(bfr_pkg::OP_CHAR, "A");
    add_item(bfr_pkg::OP_CHAR, bfr_pkg::CHAR_FIRST);
    add_item(bfr_pkg::OP_CHAR, CHAR_LAST);
    add_item(bfr_pkg::OP_CHAR, 8'd47);
    add_item(bfr_pkg::OP_CHAR, 8'd31);
    add_item(bfr_pkg::OP_CHAR, 8'd128);
    add_item(bfr_pkg::OP_CHAR, 8'd255);
    add_item(bfr_pkg::OP_CHAR, 8'd0);
    add_item(bfr_pkg::OP_CHAR, bfr_pkg::CHAR_LF);
    add_item(bfr_pkg::OP_CHAR, "B");
    add_item(bfr_pkg::OP_CHAR, bfr_pkg::CHAR_CR);
    add_item(bfr_pkg::OP_CHAR, "C");
    add_item(bfr_pkg::OP_NONE, 8'd255);
    add_item(bfr_pkg::OP_START, 8'd255);
    add_item(bfr_pkg::OP_CHAR, "D");
    wait_idle();

    set_picture(0, 0, 1024, 1024);
    add_item(bfr_pkg::OP_START, 8'd0);
    add_random_items(RANDOM_PER_PHASE);
    wait_idle();

    // Origin beyond a one-pixel picture: every line stops at once.
    set_picture(1023, 1023, 1, 1);
    add_item(bfr_pkg::OP_START, 8'd0);
    add_item(bfr_pkg::OP_CHAR, "A");
    add_item(bfr_pkg::OP_CHAR, 8'd200);
    add_item(bfr_pkg::OP_CHAR, bfr_pkg::CHAR_LF);
    add_item(bfr_pkg::OP_START, 8'd0);
    add_item(bfr_pkg::OP_CHAR, bfr_pkg::CHAR_LF);
    add_item(bfr_pkg::OP_START, 8'd0);
    add_item(bfr_pkg::OP_CHAR, 8'd5);
    add_random_items(RANDOM_PER_PHASE);
    wait_idle();

    // Origin right of the picture edge: glyphs land outside, columns wrap.
    set_picture(1020, 0, 100, 300);
    add_item(bfr_pkg::OP_START, 8'd0);
    add_item(bfr_pkg::OP_CHAR, "E");
    add_item(bfr_pkg::OP_CHAR, "F");
    add_random_items(RANDOM_PER_PHASE);
    wait_idle();

    set_picture($urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(1, 1024), $urandom_range(1, 1024));
    add_item(bfr_pkg::OP_START, 8'd0);
    add_random_items(RANDOM_PER_PHASE);
    wait_idle();

    set_picture($urandom_range(0, 40), $urandom_range(0, 40),
                $urandom_range(1, 200), $urandom_range(1, 120));
    add_item(bfr_pkg::OP_START, 8'd0);
    add_random_items(RANDOM_PER_PHASE);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("bitmap_font_text_renderer_top verification clean");
    end else begin
      $display("bitmap_font_text_renderer_top verification failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("bitmap_font_text_renderer_top verification failed");
    $finish;
  end

endmodule
